// ===== rtl/qsm3_pkg.sv =====
// ----------------------------------------------------------------------------
// qsm3_pkg
// Shared types for the median-of-three quicksort unit: controller states,
// datapath operations and the command / status bundles between them.
// ----------------------------------------------------------------------------
`default_nettype none

package qsm3_pkg;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_SORT_INIT,
        ST_POP,
        ST_POP_WAIT,
        ST_MED_RD,
        ST_MED_RD2,
        ST_MED_SEL,
        ST_SWAP_HI,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_SCAN_W2,
        ST_FIN_RD,
        ST_FIN_W1,
        ST_FIN_W2,
        ST_PUSH_L,
        ST_PUSH_R,
        ST_EMIT_RD,
        ST_EMIT_LD
    } qsm3_state_t;

    typedef enum logic [4:0] {
        OP_LOAD,
        OP_SORT_INIT,
        OP_POP,
        OP_POP_WAIT,
        OP_MED_RD,
        OP_MED_RD2,
        OP_MED_SEL,
        OP_SWAP_HI,
        OP_SCAN_RD,
        OP_SCAN_EV,
        OP_SCAN_W2,
        OP_FIN_RD,
        OP_FIN_W1,
        OP_FIN_W2,
        OP_PUSH_L,
        OP_PUSH_R,
        OP_EMIT_RD,
        OP_EMIT_LD
    } qsm3_op_t;

    typedef struct packed {
        qsm3_op_t op;
    } qsm3_cmd_t;

    typedef struct packed {
        logic in_last_fire;
        logic less;
        logic lo_eq_hi;
        logic i_last;
        logic sp_zero;
        logic push_r_ok;
        logic emit_last;
        logic out_free;
    } qsm3_status_t;

endpackage

`default_nettype wire

// ===== rtl/qsm3_if.sv =====
// ----------------------------------------------------------------------------
// qsm3 channel interfaces
// Valid / ready channels for input items and sorted result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface qsm3_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] value;
    logic                         is_last;

    modport source (output valid, output value, output is_last, input ready);
    modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface qsm3_out_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] sorted_value;
    logic                         end_of_set;
    logic                         overflowed;

    modport source (output valid, output sorted_value, output end_of_set,
                    output overflowed, input ready);
    modport sink   (input valid, input sorted_value, input end_of_set,
                    input overflowed, output ready);
endinterface

`default_nettype wire

// ===== rtl/qsm3_ctrl.sv =====
// ----------------------------------------------------------------------------
// qsm3_ctrl
// Sequencer for load, range pop, median pick, Lomuto partition, range push
// and result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module qsm3_ctrl (
    input  wire                   clk,
    input  wire                   rst_n,
    input  qsm3_pkg::qsm3_status_t status,
    output qsm3_pkg::qsm3_cmd_t    cmd
);

    qsm3_pkg::qsm3_state_t state_reg;
    qsm3_pkg::qsm3_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= qsm3_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            qsm3_pkg::ST_LOAD:
            begin
                if (status.in_last_fire)
                begin
                    state_next = qsm3_pkg::ST_SORT_INIT;
                end
            end
            qsm3_pkg::ST_SORT_INIT: state_next = qsm3_pkg::ST_POP;
            qsm3_pkg::ST_POP:       state_next = qsm3_pkg::ST_POP_WAIT;
            qsm3_pkg::ST_POP_WAIT:  state_next = qsm3_pkg::ST_MED_RD;
            qsm3_pkg::ST_MED_RD:    state_next = qsm3_pkg::ST_MED_RD2;
            qsm3_pkg::ST_MED_RD2:   state_next = qsm3_pkg::ST_MED_SEL;
            qsm3_pkg::ST_MED_SEL:   state_next = qsm3_pkg::ST_SWAP_HI;
            qsm3_pkg::ST_SWAP_HI:
            begin
                state_next = status.lo_eq_hi ? qsm3_pkg::ST_FIN_RD : qsm3_pkg::ST_SCAN_RD;
            end
            qsm3_pkg::ST_SCAN_RD:   state_next = qsm3_pkg::ST_SCAN_EV;
            qsm3_pkg::ST_SCAN_EV:
            begin
                if (status.less)
                begin
                    state_next = qsm3_pkg::ST_SCAN_W2;
                end
                else
                begin
                    state_next = status.i_last ? qsm3_pkg::ST_FIN_RD : qsm3_pkg::ST_SCAN_RD;
                end
            end
            qsm3_pkg::ST_SCAN_W2:
            begin
                state_next = status.i_last ? qsm3_pkg::ST_FIN_RD : qsm3_pkg::ST_SCAN_RD;
            end
            qsm3_pkg::ST_FIN_RD:    state_next = qsm3_pkg::ST_FIN_W1;
            qsm3_pkg::ST_FIN_W1:    state_next = qsm3_pkg::ST_FIN_W2;
            qsm3_pkg::ST_FIN_W2:    state_next = qsm3_pkg::ST_PUSH_L;
            qsm3_pkg::ST_PUSH_L:    state_next = qsm3_pkg::ST_PUSH_R;
            qsm3_pkg::ST_PUSH_R:
            begin
                if (status.sp_zero && !status.push_r_ok)
                begin
                    state_next = qsm3_pkg::ST_EMIT_RD;
                end
                else
                begin
                    state_next = qsm3_pkg::ST_POP;
                end
            end
            qsm3_pkg::ST_EMIT_RD:   state_next = qsm3_pkg::ST_EMIT_LD;
            qsm3_pkg::ST_EMIT_LD:
            begin
                if (status.out_free)
                begin
                    state_next = status.emit_last ? qsm3_pkg::ST_LOAD : qsm3_pkg::ST_EMIT_RD;
                end
            end
            default:                state_next = qsm3_pkg::ST_LOAD;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            qsm3_pkg::ST_LOAD:      cmd.op = qsm3_pkg::OP_LOAD;
            qsm3_pkg::ST_SORT_INIT: cmd.op = qsm3_pkg::OP_SORT_INIT;
            qsm3_pkg::ST_POP:       cmd.op = qsm3_pkg::OP_POP;
            qsm3_pkg::ST_POP_WAIT:  cmd.op = qsm3_pkg::OP_POP_WAIT;
            qsm3_pkg::ST_MED_RD:    cmd.op = qsm3_pkg::OP_MED_RD;
            qsm3_pkg::ST_MED_RD2:   cmd.op = qsm3_pkg::OP_MED_RD2;
            qsm3_pkg::ST_MED_SEL:   cmd.op = qsm3_pkg::OP_MED_SEL;
            qsm3_pkg::ST_SWAP_HI:   cmd.op = qsm3_pkg::OP_SWAP_HI;
            qsm3_pkg::ST_SCAN_RD:   cmd.op = qsm3_pkg::OP_SCAN_RD;
            qsm3_pkg::ST_SCAN_EV:   cmd.op = qsm3_pkg::OP_SCAN_EV;
            qsm3_pkg::ST_SCAN_W2:   cmd.op = qsm3_pkg::OP_SCAN_W2;
            qsm3_pkg::ST_FIN_RD:    cmd.op = qsm3_pkg::OP_FIN_RD;
            qsm3_pkg::ST_FIN_W1:    cmd.op = qsm3_pkg::OP_FIN_W1;
            qsm3_pkg::ST_FIN_W2:    cmd.op = qsm3_pkg::OP_FIN_W2;
            qsm3_pkg::ST_PUSH_L:    cmd.op = qsm3_pkg::OP_PUSH_L;
            qsm3_pkg::ST_PUSH_R:    cmd.op = qsm3_pkg::OP_PUSH_R;
            qsm3_pkg::ST_EMIT_RD:   cmd.op = qsm3_pkg::OP_EMIT_RD;
            qsm3_pkg::ST_EMIT_LD:   cmd.op = qsm3_pkg::OP_EMIT_LD;
            default:                cmd.op = qsm3_pkg::OP_LOAD;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/qsm3_datapath.sv =====
// ----------------------------------------------------------------------------
// qsm3_datapath
// Element store, range stack, index registers, pivot compare and output
// register of the quicksort unit.
// ----------------------------------------------------------------------------
`default_nettype none

module qsm3_datapath #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  qsm3_pkg::qsm3_cmd_t    cmd,
    output qsm3_pkg::qsm3_status_t status,
    qsm3_in_if.sink                samples,
    qsm3_out_if.source             results
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = 2 * AW;

    // element store and range stack
    logic signed [DATA_WIDTH-1:0] st_mem [DEPTH];
    logic        [SW-1:0]         stk_mem [DEPTH];

    logic                         st_we;
    logic        [AW-1:0]         st_waddr;
    logic signed [DATA_WIDTH-1:0] st_wdata;
    logic        [AW-1:0]         st_raddr_a;
    logic        [AW-1:0]         st_raddr_b;
    logic signed [DATA_WIDTH-1:0] rd_a_reg;
    logic signed [DATA_WIDTH-1:0] rd_b_reg;

    logic                         stk_we;
    logic        [AW-1:0]         stk_waddr;
    logic        [SW-1:0]         stk_wdata;
    logic        [AW-1:0]         stk_raddr;
    logic        [SW-1:0]         stk_rdata_reg;

    // control registers
    logic [CW-1:0] count_reg, count_next;
    logic          drop_reg, drop_next;
    logic [CW-1:0] sp_reg, sp_next;
    logic          out_valid_reg, out_valid_next;

    // working registers
    logic        [AW-1:0]         lo_reg, lo_next;
    logic        [AW-1:0]         hi_reg, hi_next;
    logic        [AW-1:0]         mid_reg, mid_next;
    logic        [AW-1:0]         i_reg, i_next;
    logic        [AW-1:0]         s_reg, s_next;
    logic        [AW-1:0]         k_reg, k_next;
    logic signed [DATA_WIDTH-1:0] va_reg, va_next;
    logic signed [DATA_WIDTH-1:0] vb_reg, vb_next;
    logic signed [DATA_WIDTH-1:0] pv_reg, pv_next;
    logic signed [DATA_WIDTH-1:0] tmp_reg, tmp_next;
    logic signed [DATA_WIDTH-1:0] out_value_reg, out_value_next;
    logic                         out_last_reg, out_last_next;
    logic                         out_ovf_reg, out_ovf_next;

    logic                         in_fire;
    logic                         out_free;
    logic                         out_load;
    logic        [CW-1:0]         cnt_m1;
    logic        [CW-1:0]         sp_m1;
    logic        [AW:0]           mid_sum;
    logic                         stk_room;
    logic                         push_l_ok;
    logic                         push_r_ok;
    logic        [AW-1:0]         s_p1;
    logic        [AW-1:0]         s_m1;
    logic                         less;
    logic signed [DATA_WIDTH-1:0] vc;
    logic                         med_a;
    logic                         med_c;
    logic        [AW-1:0]         piv_idx;
    logic signed [DATA_WIDTH-1:0] piv_val;

    assign samples.ready        = (cmd.op == qsm3_pkg::OP_LOAD);
    assign in_fire              = samples.valid && samples.ready;
    assign results.valid        = out_valid_reg;
    assign results.sorted_value = out_value_reg;
    assign results.end_of_set   = out_last_reg;
    assign results.overflowed   = out_ovf_reg;

    assign out_free  = !out_valid_reg || results.ready;
    assign out_load  = (cmd.op == qsm3_pkg::OP_EMIT_LD) && out_free;
    assign cnt_m1    = count_reg - CW'(1);
    assign sp_m1     = sp_reg - CW'(1);
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign stk_room  = sp_reg < CW'(DEPTH);
    assign push_l_ok = {1'b0, s_reg} >= ({1'b0, lo_reg} + (AW+1)'(2));
    assign push_r_ok = ({1'b0, s_reg} + (AW+1)'(1)) < {1'b0, hi_reg};
    assign s_p1      = s_reg + AW'(1);
    assign s_m1      = s_reg - AW'(1);
    assign less      = rd_a_reg < pv_reg;

    // median of first, last and middle; ties go to first, then middle
    assign vc    = rd_a_reg;
    assign med_a = (va_reg >= vb_reg && va_reg <= vc) || (va_reg >= vc && va_reg <= vb_reg);
    assign med_c = (vc >= vb_reg && vc <= va_reg) || (vc >= va_reg && vc <= vb_reg);

    always_comb
    begin
        if (med_a)
        begin
            piv_idx = lo_reg;
            piv_val = va_reg;
        end
        else if (med_c)
        begin
            piv_idx = mid_reg;
            piv_val = vc;
        end
        else
        begin
            piv_idx = hi_reg;
            piv_val = vb_reg;
        end
    end

    assign status.in_last_fire = in_fire && samples.is_last;
    assign status.less         = less;
    assign status.lo_eq_hi     = (lo_reg == hi_reg);
    assign status.i_last       = ({1'b0, i_reg} + (AW+1)'(1)) == {1'b0, hi_reg};
    assign status.sp_zero      = (sp_reg == '0);
    assign status.push_r_ok    = push_r_ok;
    assign status.emit_last    = ({1'b0, k_reg} == cnt_m1);
    assign status.out_free     = out_free;

    always_comb
    begin
        count_next     = count_reg;
        drop_next      = drop_reg;
        sp_next        = sp_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        i_next         = i_reg;
        s_next         = s_reg;
        k_next         = k_reg;
        va_next        = va_reg;
        vb_next        = vb_reg;
        pv_next        = pv_reg;
        tmp_next       = tmp_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        st_we          = 1'b0;
        st_waddr       = '0;
        st_wdata       = '0;
        st_raddr_a     = '0;
        st_raddr_b     = '0;
        stk_we         = 1'b0;
        stk_waddr      = '0;
        stk_wdata      = '0;
        stk_raddr      = '0;

        case (cmd.op)
            qsm3_pkg::OP_LOAD:
            begin
                if (in_fire)
                begin
                    if (count_reg < CW'(DEPTH))
                    begin
                        st_we      = 1'b1;
                        st_waddr   = count_reg[AW-1:0];
                        st_wdata   = samples.value;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                end
            end
            qsm3_pkg::OP_SORT_INIT:
            begin
                stk_we    = 1'b1;
                stk_waddr = '0;
                stk_wdata = {AW'(0), cnt_m1[AW-1:0]};
                sp_next   = CW'(1);
                k_next    = '0;
            end
            qsm3_pkg::OP_POP:
            begin
                stk_raddr = sp_m1[AW-1:0];
                sp_next   = sp_m1;
            end
            qsm3_pkg::OP_POP_WAIT:
            begin
                lo_next = stk_rdata_reg[SW-1:AW];
                hi_next = stk_rdata_reg[AW-1:0];
            end
            qsm3_pkg::OP_MED_RD:
            begin
                st_raddr_a = lo_reg;
                st_raddr_b = hi_reg;
                mid_next   = mid_sum[AW:1];
            end
            qsm3_pkg::OP_MED_RD2:
            begin
                st_raddr_a = mid_reg;
                va_next    = rd_a_reg;
                vb_next    = rd_b_reg;
            end
            qsm3_pkg::OP_MED_SEL:
            begin
                st_we    = 1'b1;
                st_waddr = piv_idx;
                st_wdata = vb_reg;
                pv_next  = piv_val;
                i_next   = lo_reg;
                s_next   = lo_reg;
            end
            qsm3_pkg::OP_SWAP_HI:
            begin
                st_we    = 1'b1;
                st_waddr = hi_reg;
                st_wdata = pv_reg;
            end
            qsm3_pkg::OP_SCAN_RD:
            begin
                st_raddr_a = i_reg;
                st_raddr_b = s_reg;
            end
            qsm3_pkg::OP_SCAN_EV:
            begin
                if (less)
                begin
                    st_we    = 1'b1;
                    st_waddr = s_reg;
                    st_wdata = rd_a_reg;
                    tmp_next = rd_b_reg;
                end
                else
                begin
                    i_next = i_reg + AW'(1);
                end
            end
            qsm3_pkg::OP_SCAN_W2:
            begin
                st_we    = 1'b1;
                st_waddr = i_reg;
                st_wdata = tmp_reg;
                s_next   = s_p1;
                i_next   = i_reg + AW'(1);
            end
            qsm3_pkg::OP_FIN_RD:
            begin
                st_raddr_b = s_reg;
            end
            qsm3_pkg::OP_FIN_W1:
            begin
                st_we    = 1'b1;
                st_waddr = hi_reg;
                st_wdata = rd_b_reg;
            end
            qsm3_pkg::OP_FIN_W2:
            begin
                st_we    = 1'b1;
                st_waddr = s_reg;
                st_wdata = pv_reg;
            end
            qsm3_pkg::OP_PUSH_L:
            begin
                if (push_l_ok && stk_room)
                begin
                    stk_we    = 1'b1;
                    stk_waddr = sp_reg[AW-1:0];
                    stk_wdata = {lo_reg, s_m1};
                    sp_next   = sp_reg + CW'(1);
                end
            end
            qsm3_pkg::OP_PUSH_R:
            begin
                if (push_r_ok && stk_room)
                begin
                    stk_we    = 1'b1;
                    stk_waddr = sp_reg[AW-1:0];
                    stk_wdata = {s_p1, hi_reg};
                    sp_next   = sp_reg + CW'(1);
                end
            end
            qsm3_pkg::OP_EMIT_RD:
            begin
                st_raddr_a = k_reg;
            end
            qsm3_pkg::OP_EMIT_LD:
            begin
                st_raddr_a = k_reg;
                if (out_free)
                begin
                    out_value_next = rd_a_reg;
                    out_last_next  = status.emit_last;
                    out_ovf_next   = drop_reg;
                    k_next         = k_reg + AW'(1);
                    if (status.emit_last)
                    begin
                        count_next = '0;
                        drop_next  = 1'b0;
                        sp_next    = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            sp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            sp_reg        <= sp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        mid_reg       <= mid_next;
        i_reg         <= i_next;
        s_reg         <= s_next;
        k_reg         <= k_next;
        va_reg        <= va_next;
        vb_reg        <= vb_next;
        pv_reg        <= pv_next;
        tmp_reg       <= tmp_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_ovf_reg   <= out_ovf_next;
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem[st_waddr] <= st_wdata;
        end
        rd_a_reg <= st_mem[st_raddr_a];
        rd_b_reg <= st_mem[st_raddr_b];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_rdata_reg <= stk_mem[stk_raddr];
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("element count above capacity");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= CW'(DEPTH))
        else $error("range stack above capacity");

    a_scan_order: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == qsm3_pkg::OP_SCAN_RD) |-> (s_reg <= i_reg && i_reg < hi_reg))
        else $error("partition indexes out of order");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.op == qsm3_pkg::OP_EMIT_LD))
        else $error("result item raised outside emission");

endmodule

`default_nettype wire

// ===== rtl/quicksort_median_of_three_unit.sv =====
// ----------------------------------------------------------------------------
// quicksort_median_of_three_unit
// Collects a set of signed values, sorts it in place with an iterative
// median-of-three quicksort and streams the values out in ascending order.
// ----------------------------------------------------------------------------
// channel   dir  payload                                  notes
// samples   in   value, is_last                           is_last starts sort
// results   out  sorted_value, end_of_set, overflowed     one item per element
//
// loading accepts items back to back; items past DEPTH are dropped and flagged
// sorting: a scanned element that moves takes an extra write state, since
// the element store has a single write port
// emission reads each result and then loads it into the output register
// rst_n clears the counters and the stack pointer; store contents are not reset
// a stalled results channel holds emission; samples is not ready until the
// last item of the previous set sits in the output register
`default_nettype none

module quicksort_median_of_three_unit #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire        clk,
    input  wire        rst_n,
    qsm3_in_if.sink    samples,
    qsm3_out_if.source results
);

    qsm3_pkg::qsm3_cmd_t    cmd;
    qsm3_pkg::qsm3_status_t status;

    qsm3_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    qsm3_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .status  (status),
        .samples (samples),
        .results (results)
    );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for quicksort_median_of_three_unit. Sets of signed values are
// streamed in. Each set is directed, random, equal-keyed, ordered, filled to
// the store depth, or long enough to overflow the store. A local model keeps
// each set and sorts it on the last item. Every sorted item that comes out is
// checked in order against that model. The run steps through phases of
// sender idling and receiver stalling, and holds the receiver off for a long
// stretch to back up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH       = 64;
    localparam int DATA_WIDTH  = 32;
    localparam int HOLD_CYCLES = 600;
    localparam int PRINT_LIMIT = 40;

    typedef logic signed [DATA_WIDTH-1:0] word_t;

    localparam word_t WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef struct packed {
        word_t value;
        logic  is_last;
    } sample_t;

    typedef struct packed {
        word_t value;
        logic  end_of_set;
        logic  overflowed;
    } sorted_t;

    logic clk;
    logic rst_n;

    qsm3_in_if  #(.DATA_WIDTH(DATA_WIDTH)) samples ();
    qsm3_out_if #(.DATA_WIDTH(DATA_WIDTH)) results ();

    quicksort_median_of_three_unit #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .results (results)
    );

    sample_t pending_samples[$];
    sorted_t expected_sorted[$];

    word_t set_store[DEPTH];
    int    set_count;
    logic  set_dropped;

    int    queued_count;
    int    accepted_count;
    int    mismatch_count;
    int    send_idle_pct;
    int    recv_stall_pct;
    logic  sample_taken;
    logic  holding;

    event  hold_start;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // insertion sort of the collected set, then one sorted item per element
    task automatic sort_and_emit();
        word_t   key;
        int      j;
        sorted_t item;
        for (int i = 1; i < set_count; i++)
        begin
            key = set_store[i];
            j = i - 1;
            while (j >= 0 && set_store[j] > key)
            begin
                set_store[j + 1] = set_store[j];
                j--;
            end
            set_store[j + 1] = key;
        end
        for (int k = 0; k < set_count; k++)
        begin
            item.value      = set_store[k];
            item.end_of_set = (k == set_count - 1);
            item.overflowed = set_dropped;
            expected_sorted.push_back(item);
        end
        set_count   = 0;
        set_dropped = 1'b0;
    endtask

    task automatic collect_sample(input word_t value, input logic is_last);
        if (set_count < DEPTH)
        begin
            set_store[set_count] = value;
            set_count++;
        end
        else
            set_dropped = 1'b1;
        if (is_last)
            sort_and_emit();
    endtask

    // monitor
    always @(posedge clk)
    begin
        sorted_t want;
        sample_taken = 1'b0;
        if (rst_n)
        begin
            if (samples.valid && samples.ready)
            begin
                sample_taken = 1'b1;
                accepted_count++;
                collect_sample(samples.value, samples.is_last);
            end
            if (results.valid && results.ready)
            begin
                if (expected_sorted.size() == 0)
                    report_mismatch("unexpected sorted item, value", results.sorted_value, 0);
                else
                begin
                    want = expected_sorted.pop_front();
                    if (results.sorted_value !== want.value)
                        report_mismatch("sorted_value", results.sorted_value, want.value);
                    if (results.end_of_set !== want.end_of_set)
                        report_mismatch("end_of_set", results.end_of_set, want.end_of_set);
                    if (results.overflowed !== want.overflowed)
                        report_mismatch("overflowed", results.overflowed, want.overflowed);
                end
            end
        end
    end

    // driver
    always @(negedge clk)
    begin
        sample_t nxt;
        if (rst_n)
        begin
            if (samples.valid && !sample_taken)
            begin
            end
            else if (pending_samples.size() != 0 &&
                     !(send_idle_pct != 0 && $urandom_range(99) < send_idle_pct))
            begin
                nxt = pending_samples.pop_front();
                samples.valid   <= 1'b1;
                samples.value   <= nxt.value;
                samples.is_last <= nxt.is_last;
            end
            else
                samples.valid <= 1'b0;
            results.ready <= !holding &&
                             !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    // long receiver hold-off
    always
    begin
        @(hold_start);
        holding = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
    end

    task automatic add_sample(input word_t value, input logic is_last);
        sample_t s;
        s.value   = value;
        s.is_last = is_last;
        pending_samples.push_back(s);
        queued_count++;
    endtask

    task automatic add_set(input int n, input int shape);
        word_t v;
        word_t base;
        base = $urandom;
        for (int i = 0; i < n; i++)
        begin
            case (shape)
                2: v = $signed($urandom_range(8)) - 4;
                3: v = base + i * $urandom_range(3);
                4: v = base - i * $urandom_range(3);
                5:
                begin
                    case ($urandom_range(5))
                        0: v = WORD_MIN;
                        1: v = WORD_MAX;
                        2: v = WORD_MIN + 1;
                        3: v = WORD_MAX - 1;
                        4: v = 0;
                        default: v = -1;
                    endcase
                end
                6: v = base;
                default: v = $urandom;
            endcase
            add_sample(v, i == n - 1);
        end
    endtask

    task automatic add_random_sets(input int items);
        int done_items;
        int n;
        int r;
        done_items = 0;
        while (done_items < items)
        begin
            r = $urandom_range(99);
            if (r < 4)
                n = $urandom_range(72, 65);
            else if (r < 10)
                n = $urandom_range(64, 40);
            else
                n = $urandom_range(16, 1);
            add_set(n, $urandom_range(7));
            done_items += n;
        end
    endtask

    task automatic wait_drained();
        while (pending_samples.size() != 0 || accepted_count != queued_count ||
               expected_sorted.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n           = 1'b0;
        samples.valid   = 1'b0;
        samples.value   = '0;
        samples.is_last = 1'b0;
        results.ready   = 1'b0;
        holding         = 1'b0;
        sample_taken    = 1'b0;
        set_count       = 0;
        set_dropped     = 1'b0;
        queued_count    = 0;
        accepted_count  = 0;
        mismatch_count  = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed sets
        add_sample(WORD_MAX, 1'b1);
        add_sample(WORD_MIN, 1'b1);
        add_sample(0, 1'b0);
        add_sample(-1, 1'b0);
        add_sample(1, 1'b0);
        add_sample(WORD_MAX, 1'b0);
        add_sample(WORD_MIN, 1'b0);
        add_sample(5, 1'b0);
        add_sample(5, 1'b0);
        add_sample(WORD_MIN, 1'b0);
        add_sample(WORD_MAX, 1'b0);
        add_sample(-5, 1'b1);
        add_sample(3, 1'b0);
        add_sample(3, 1'b0);
        add_sample(3, 1'b1);
        add_sample(2, 1'b0);
        add_sample(1, 1'b1);
        add_sample(1, 1'b0);
        add_sample(2, 1'b1);
        wait_drained();

        // store exactly full, then overflow with the last six items dropped
        add_set(DEPTH, 0);
        add_set(DEPTH + 6, 0);
        add_random_sets(50);
        wait_drained();

        // receiver held off while the sender keeps offering
        add_set(12, 0);
        add_set(12, 2);
        add_set(12, 4);
        -> hold_start;
        wait_drained();

        send_idle_pct = 78;
        add_random_sets(75);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 78;
        add_random_sets(75);
        wait_drained();

        send_idle_pct  = 8;
        recv_stall_pct = 8;
        add_random_sets(75);
        wait_drained();

        repeat (50) @(posedge clk);
        if (mismatch_count == 0)
            $display("quicksort_median_of_three_unit regression: pass");
        else
            $display("quicksort_median_of_three_unit regression: fail");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("quicksort_median_of_three_unit regression: fail");
        $finish;
    end

endmodule
